/* design/skt_pkg.sv */
`timescale 1ns / 1ps
package skt_pkg;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   localparam int KEY_W    = 15;
   localparam int HANDLE_W = 8;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;

   typedef struct packed {
      logic [1:0]          op;
      logic [KEY_W-1:0]    search_key;
      logic [HANDLE_W-1:0] entry_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [POS_W-1:0]    found_position;
      logic [HANDLE_W-1:0] found_handle;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   // sequencer status toward the top level
   typedef struct packed {
      logic idle;
      logic done;
   } ctrl_stat_type;

endpackage

/* design/skt_entry_ram.sv */
`timescale 1ns / 1ps
module skt_entry_ram
   import skt_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  entry_type                wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output entry_type                rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/skt_ctrl.sv */
`timescale 1ns / 1ps
module skt_ctrl
   import skt_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  req_type                     req,
   input  logic                        res_free,
   output ctrl_stat_type               stat,
   output rsp_type                     res,
   output logic                        mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
   output entry_type                   mem_wr_data,
   output logic                        mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
   input  entry_type                   mem_rd_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SRCH_RD  = 3'd1;
   localparam logic [2:0] S_SRCH_CMP = 3'd2;
   localparam logic [2:0] S_SH_RD    = 3'd3;
   localparam logic [2:0] S_SH_WR    = 3'd4;
   localparam logic [2:0] S_FIN      = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    hi_ff, hi_in;      // exclusive upper bound
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    mid_ff, mid_in;
   rsp_type             res_ff, res_in;

   logic                is_insert;
   logic                is_remove;
   logic [CNT_W:0]      mid_sum;
   logic [CNT_W-1:0]    mid;
   logic                key_lt;
   logic                key_eq;
   logic [CNT_W-1:0]    res_pos;
   logic [1:0]          res_status;
   logic [HANDLE_W-1:0] res_handle;
   logic [CNT_W-1:0]    res_count;
   logic                res_load;

   function automatic logic [IDX_W-1:0] ptr_in_prev(input logic [CNT_W-1:0] p);
      logic [CNT_W-1:0] t;
      t = p - CNT_W'(1);
      return t[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] ptr_in_next(input logic [CNT_W-1:0] p);
      logic [CNT_W-1:0] t;
      t = p + CNT_W'(1);
      return t[IDX_W-1:0];
   endfunction

   assign is_insert = (op_ff == OP_INSERT);
   assign is_remove = (op_ff == OP_REMOVE);

   // midpoint: lower bound uses floor((lo+hi)/2) with hi exclusive,
   // exact match search uses floor((lo+hi-1)/2)
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} - {{CNT_W{1'b0}}, !is_insert};
   assign mid     = mid_sum[CNT_W:1];

   // shared key comparator
   assign key_lt = (mem_rd_data.key < key_ff);
   assign key_eq = (mem_rd_data.key == key_ff);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      handle_in   = handle_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      ptr_in      = ptr_ff;
      count_in    = count_ff;
      mid_in      = mid_ff;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = ptr_ff[IDX_W-1:0];
      mem_wr_data = mem_rd_data;
      mem_rd_en   = 1'b0;
      mem_rd_addr = mid[IDX_W-1:0];
      res_load    = 1'b0;
      res_pos     = lo_ff;
      res_status  = ST_NOT_FOUND;
      res_handle  = '0;
      res_count   = count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req.op;
               key_in    = req.search_key;
               handle_in = req.entry_handle;
               lo_in     = '0;
               hi_in     = count_ff;
               if (req.op == OP_INSERT && count_ff == CNT_W'(CAPACITY)) begin
                  res_load   = 1'b1;
                  res_status = ST_FULL;
                  state_in   = S_FIN;
               end else begin
                  state_in = S_SRCH_RD;
               end
            end
         end
         S_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               mem_rd_en = 1'b1;
               mid_in    = mid;
               state_in  = S_SRCH_CMP;
            end else if (is_insert) begin
               ptr_in   = count_ff;
               state_in = S_SH_RD;
            end else begin
               res_load   = 1'b1;
               res_status = ST_NOT_FOUND;
               state_in   = S_FIN;
            end
         end
         S_SRCH_CMP: begin
            state_in = S_SRCH_RD;
            if (is_insert) begin
               if (key_lt) begin
                  lo_in = mid_ff + CNT_W'(1);
               end else begin
                  hi_in = mid_ff;
               end
            end else if (key_eq) begin
               lo_in     = mid_ff;
               handle_in = mem_rd_data.handle;
               if (is_remove) begin
                  ptr_in   = mid_ff;
                  state_in = S_SH_RD;
               end else begin
                  // lookup, also taken by the unused op code
                  res_load   = 1'b1;
                  res_pos    = mid_ff;
                  res_status = ST_OK;
                  res_handle = mem_rd_data.handle;
                  state_in   = S_FIN;
               end
            end else if (key_lt) begin
               lo_in = mid_ff + CNT_W'(1);
            end else begin
               hi_in = mid_ff;
            end
         end
         S_SH_RD: begin
            if (is_insert) begin
               if (ptr_ff > lo_ff) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = ptr_in_prev(ptr_ff);
                  state_in    = S_SH_WR;
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = '{key: key_ff, handle: handle_ff};
                  count_in    = count_ff + CNT_W'(1);
                  res_load    = 1'b1;
                  res_status  = ST_OK;
                  res_handle  = handle_ff;
                  res_count   = count_in;
                  state_in    = S_FIN;
               end
            end else begin
               if (ptr_ff + CNT_W'(1) < count_ff) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = ptr_in_next(ptr_ff);
                  state_in    = S_SH_WR;
               end else begin
                  count_in   = count_ff - CNT_W'(1);
                  res_load   = 1'b1;
                  res_status = ST_OK;
                  res_handle = handle_ff;
                  res_count  = count_in;
                  state_in   = S_FIN;
               end
            end
         end
         S_SH_WR: begin
            mem_wr_en = 1'b1;
            ptr_in    = is_insert ? ptr_ff - CNT_W'(1) : ptr_ff + CNT_W'(1);
            state_in  = S_SH_RD;
         end
         S_FIN: begin
            if (res_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (res_load) begin
         res_in.status         = res_status;
         res_in.found_position = (res_status == ST_OK) ? POS_W'(res_pos) : '0;
         res_in.found_handle   = res_handle;
         res_in.entry_count    = COUNT_W'(res_count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      handle_ff <= handle_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      ptr_ff    <= ptr_in;
      mid_ff    <= mid_in;
      res_ff    <= res_in;
   end

   assign stat.idle = (state_ff == S_IDLE);
   assign stat.done = (state_ff == S_FIN) && res_free;
   assign res       = res_ff;

endmodule

/* design/sorted_key_table.sv */
`timescale 1ns / 1ps
// Sorted key table: up to CAPACITY entries held in ascending key order in a
// single-port-per-side entry RAM, each with an 8-bit handle. Insert places
// the new entry ahead of the first entry with an equal or larger key
// (duplicates allowed), remove deletes one matching entry and closes the
// gap, lookup reports position and handle; every transaction returns one
// response carrying the entry count. One transaction is processed at a
// time: each binary search step reads the RAM at the midpoint in S_SRCH_RD
// and compares the registered read data in S_SRCH_CMP, and each entry
// moved by an insert or remove is read in S_SH_RD and written one place
// over in S_SH_WR. A full-table insert skips the search and answers
// with ST_FULL. The response register lets a new request enter while the
// previous response waits.
module sorted_key_table
   import skt_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);

   ctrl_stat_type    stat;
   rsp_type          res;
   logic             res_free;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   entry_type        mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   entry_type        mem_rd_data;

   // sequencer takes a new transaction only when it is idle
   assign req_stall = !stat.idle;

   // response slot frees when empty or being taken this cycle
   assign res_free = !rsp_valid_ff || !rsp_stall;

   skt_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (req_valid && !req_stall),
      .req        (req_data),
      .res_free   (res_free),
      .stat       (stat),
      .res        (res),
      .mem_wr_en  (mem_wr_en),
      .mem_wr_addr(mem_wr_addr),
      .mem_wr_data(mem_wr_data),
      .mem_rd_en  (mem_rd_en),
      .mem_rd_addr(mem_rd_addr),
      .mem_rd_data(mem_rd_data)
   );

   skt_entry_ram #(
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   // response output register
   assign rsp_valid_in = stat.done || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.done) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // a finished result never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      stat.done |-> !(rsp_valid_ff && rsp_stall))
      else $error("response overwritten while stalled");

   // an accepted request makes the block busy on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted without going busy");

   // failed transactions report zero position and handle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |->
         (rsp_data.found_position == '0 && rsp_data.found_handle == '0))
      else $error("failed response carries position or handle");

   // no RAM access while idle
   assert property (@(posedge clock) disable iff (reset)
      stat.idle |-> (!mem_wr_en && !mem_rd_en))
      else $error("RAM access while idle");
`endif

endmodule
